### sv/hht_pkg.sv
// Package for the multistage heavy hitter table.
// Holds field widths, codes, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package hht_pkg;

  localparam int KEY_W      = 32;
  localparam int RND_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 31;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_SEEDS  = 6;

  localparam logic [31:0]        HASH_MULT = 32'h9E37_79B1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [OUTCOME_W-1:0] OUTCOME_ABSORBED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACED = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_QUERY    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RECIP,
    ST_QMUL,
    ST_INDEX,
    ST_EVAL,
    ST_COMMIT
  } hht_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash;
    logic recip;
    logic qmul;
    logic index;
    logic eval;
    logic commit;
  } hht_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } hht_sts_t;

endpackage

`default_nettype wire

### sv/hht_in_if.sv
// Request channel into the heavy hitter table: valid/ready plus the item fields.
// Depends on hht_pkg for field widths.
`default_nettype none

interface hht_in_if import hht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] flow_key;
  logic [RND_W-1:0] random_bits;

  modport source (output valid, output mode, output flow_key, output random_bits,
                  input ready);
  modport sink   (input valid, input mode, input flow_key, input random_bits,
                  output ready);
endinterface

`default_nettype wire

### sv/hht_out_if.sv
// Result channel out of the heavy hitter table: valid/ready plus the result fields.
// Depends on hht_pkg for field widths.
`default_nettype none

interface hht_out_if import hht_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [KEY_W-1:0]     out_key;
  logic [KEY_W-1:0]     out_count;
  logic [TOTAL_W-1:0]   query_total;

  modport source (output valid, output outcome, output out_key, output out_count,
                  output query_total, input ready);
  modport sink   (input valid, input outcome, input out_key, input out_count,
                  input query_total, output ready);
endinterface

`default_nettype wire

### sv/multistage_heavy_hitter_table.sv
// Multistage heavy hitter table: a set of hashed stages of key/count slots.
// Requests arrive on in_chan (mode 0 inserts flow_key, mode 1 queries its count),
// one result per request leaves on out_chan; seeds are written through cfg_*.
// A request is registered on acceptance, then steps through hash, reciprocal,
// quotient multiply, index, evaluate and commit; a new request is taken the cycle
// after the previous result is registered. The steps follow the hash and slot-index
// arithmetic (three chained multiplies) and the read-modify-write of the stage RAMs.
// After reset the stage RAMs are cleared one row per cycle, all SLOTS_PER_STAGE rows,
// with in_chan.ready low; seed writes are taken during that time as always.
// The result sits in an output register: the next request is accepted while it
// waits, and only the commit of that next request waits for out_chan.ready.
// The user must write seeds only while no request is in flight (not enforced).
// Depends on hht_pkg, hht_in_if, hht_out_if, hht_ctrl, hht_dp and hht_ram.
`default_nettype none

module multistage_heavy_hitter_table import hht_pkg::*; #(
  parameter int STAGES          = 6,
  parameter int SLOTS_PER_STAGE = 1024,
  parameter int KEY_BITS        = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hht_in_if.sink                     in_chan,
  hht_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  hht_cmd_t cmd;
  hht_sts_t sts;

  hht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hht_dp #(
    .STAGES          (STAGES),
    .SLOTS_PER_STAGE (SLOTS_PER_STAGE),
    .KEY_BITS        (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_chan.mode),
    .in_flow_key    (in_chan.flow_key),
    .in_random_bits (in_chan.random_bits),
    .res_valid      (out_chan.valid),
    .res_ready      (out_chan.ready),
    .res_outcome    (out_chan.outcome),
    .res_key        (out_chan.out_key),
    .res_count      (out_chan.out_count),
    .res_total      (out_chan.query_total)
  );

endmodule

`default_nettype wire

### sv/hht_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module hht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/hht_ctrl.sv
// Controller of the heavy hitter table: clearing pass, request intake and step sequencing.
// Depends on hht_pkg for the state type and the command/status structs.
`default_nettype none

module hht_ctrl import hht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire hht_sts_t sts,
  output      hht_cmd_t cmd
);

  hht_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HASH;
      end
      ST_HASH:  state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_QMUL;
      ST_QMUL:  state_nxt = ST_INDEX;
      ST_INDEX: state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_HASH:   cmd.hash   = 1'b1;
      ST_RECIP:  cmd.recip  = 1'b1;
      ST_QMUL:   cmd.qmul   = 1'b1;
      ST_INDEX:  cmd.index  = 1'b1;
      ST_EVAL:   cmd.eval   = 1'b1;
      ST_COMMIT: cmd.commit = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed while the output register is still occupied");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> $past(cmd.index))
    else $error("evaluation without a preceding slot read");

endmodule

`default_nettype wire

### sv/hht_dp.sv
// Datapath of the heavy hitter table: seeds, hash and slot index, stage RAMs, decision, result.
// Depends on hht_pkg and hht_ram; sequenced by commands from hht_ctrl.
`default_nettype none

module hht_dp import hht_pkg::*; #(
  parameter int STAGES          = 6,
  parameter int SLOTS_PER_STAGE = 1024,
  parameter int KEY_BITS        = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hht_cmd_t              cmd,
  output      hht_sts_t              sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_mode,
  input  wire logic [KEY_W-1:0]      in_flow_key,
  input  wire logic [RND_W-1:0]      in_random_bits,
  output      logic                  res_valid,
  input  wire logic                  res_ready,
  output      logic [OUTCOME_W-1:0]  res_outcome,
  output      logic [KEY_W-1:0]      res_key,
  output      logic [KEY_W-1:0]      res_count,
  output      logic [TOTAL_W-1:0]    res_total
);

  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W = $clog2(SLOTS_PER_STAGE);
  localparam int R_W   = IDX_W + 2;
  localparam int ST_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int ENT_W = KW + COUNT_W;
  localparam int SUM_W = COUNT_W + 3;
  localparam logic [31:0]    RECIP   = 32'((64'd1 << 32) / 64'(SLOTS_PER_STAGE));
  localparam logic [31:0]    SLOTS32 = 32'(SLOTS_PER_STAGE);
  localparam logic [R_W-1:0] SLOTS_R = R_W'(SLOTS_PER_STAGE);

  logic [31:0]      seed_r [NUM_SEEDS];
  logic             mode_r;
  logic [KW-1:0]    key_r;
  logic [RND_W-1:0] rnd_r;
  logic [IDX_W-1:0] clr_cnt_r;

  logic [ENT_W-1:0] rd_ent [STAGES];
  logic [IDX_W-1:0] idx_w  [STAGES];
  logic [ENT_W-1:0] wdata;

  logic               hit_any_r, hit_empty_r;
  logic [ST_W-1:0]    hit_stage_r, min_stage_r;
  logic [COUNT_W-1:0] hit_cnt_r, min_cnt_r;
  logic [KW-1:0]      min_key_r;
  logic [TOTAL_W-1:0] total_r;

  logic               hit_any_nxt, hit_empty_nxt;
  logic [ST_W-1:0]    hit_stage_nxt, min_stage_nxt;
  logic [COUNT_W-1:0] hit_cnt_nxt, min_cnt_nxt;
  logic [KW-1:0]      min_key_nxt;
  logic [TOTAL_W-1:0] total_nxt;

  logic                 wr_en;
  logic [ST_W-1:0]      wr_stage;
  logic [COUNT_W-1:0]   wr_cnt;
  logic [OUTCOME_W-1:0] outcome_nxt;
  logic [KEY_W-1:0]     okey_nxt, ocount_nxt;
  logic [TOTAL_W-1:0]   ototal_nxt;

  logic                 res_valid_r;
  logic [OUTCOME_W-1:0] res_outcome_r;
  logic [KEY_W-1:0]     res_key_r, res_count_r;
  logic [TOTAL_W-1:0]   res_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEEDS; i++) begin
        seed_r[i] <= 32'(i + 1);
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_SEEDS))) begin
      seed_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_flow_key[KW-1:0];
      rnd_r  <= in_random_bits;
    end
  end

  assign wdata = cmd.clear ? '0 : {key_r, wr_cnt};

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [31:0]      kx, x_w, qn_full;
    logic [63:0]      recip_prod;
    logic [31:0]      h_r, q_r;
    logic [R_W-1:0]   x_r, qn_r, r_est;
    logic [IDX_W-1:0] idx_r;
    logic             we;

    assign kx         = KEY_W'(key_r) ^ seed_r[s];
    assign x_w        = h_r ^ (h_r >> 16);
    assign recip_prod = 64'(x_w) * 64'(RECIP);
    assign qn_full    = q_r * SLOTS32;
    // The reciprocal estimate is low by at most one, so one correction suffices.
    assign r_est      = x_r - qn_r;
    assign idx_w[s]   = (r_est >= SLOTS_R) ? IDX_W'(r_est - SLOTS_R) : r_est[IDX_W-1:0];
    assign we         = cmd.clear || (cmd.commit && wr_en && (wr_stage == ST_W'(s)));

    always_ff @(posedge clk) begin
      if (cmd.hash) begin
        h_r <= kx * HASH_MULT;
      end
      if (cmd.recip) begin
        x_r <= x_w[R_W-1:0];
        q_r <= recip_prod[63:32];
      end
      if (cmd.qmul) begin
        qn_r <= qn_full[R_W-1:0];
      end
      if (cmd.index) begin
        idx_r <= idx_w[s];
      end
    end

    hht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS_PER_STAGE)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (cmd.clear ? clr_cnt_r : idx_r),
      .wdata (wdata),
      .re    (cmd.index),
      .raddr (idx_w[s]),
      .rdata (rd_ent[s])
    );
  end

  always_comb begin
    logic               found, have_min, empty, match;
    logic [KW-1:0]      k;
    logic [COUNT_W-1:0] c;
    logic [SUM_W-1:0]   sum;
    found         = 1'b0;
    have_min      = 1'b0;
    sum           = '0;
    hit_empty_nxt = 1'b0;
    hit_stage_nxt = '0;
    hit_cnt_nxt   = '0;
    min_stage_nxt = '0;
    min_cnt_nxt   = '0;
    min_key_nxt   = '0;
    for (int s = 0; s < STAGES; s++) begin
      k     = rd_ent[s][ENT_W-1:COUNT_W];
      c     = rd_ent[s][COUNT_W-1:0];
      empty = (c == '0);
      match = (k == key_r);
      if (match) sum = sum + SUM_W'(c);
      if (!found) begin
        if (empty || match) begin
          found         = 1'b1;
          hit_empty_nxt = empty;
          hit_stage_nxt = ST_W'(s);
          hit_cnt_nxt   = c;
        end else if (!have_min || (c < min_cnt_nxt)) begin
          have_min      = 1'b1;
          min_stage_nxt = ST_W'(s);
          min_cnt_nxt   = c;
          min_key_nxt   = k;
        end
      end
    end
    hit_any_nxt = found;
    total_nxt   = (sum > SUM_W'({TOTAL_W{1'b1}})) ? '1 : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_any_r   <= hit_any_nxt;
      hit_empty_r <= hit_empty_nxt;
      hit_stage_r <= hit_stage_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      min_stage_r <= min_stage_nxt;
      min_cnt_r   <= min_cnt_nxt;
      min_key_r   <= min_key_nxt;
      total_r     <= total_nxt;
    end
  end

  always_comb begin
    logic [COUNT_W-1:0] mask;
    logic               replace;
    // Smearing count-1 downward gives 2^ceil(log2(count)) - 1.
    mask        = min_cnt_r - 1'b1;
    mask        = mask | (mask >> 1);
    mask        = mask | (mask >> 2);
    mask        = mask | (mask >> 4);
    mask        = mask | (mask >> 8);
    mask        = mask | (mask >> 16);
    replace     = ((rnd_r[COUNT_W-1:0] & mask) == '0);
    wr_en       = 1'b0;
    wr_stage    = '0;
    wr_cnt      = COUNT_W'(1);
    outcome_nxt = OUTCOME_ABSORBED;
    okey_nxt    = '0;
    ocount_nxt  = '0;
    ototal_nxt  = '0;
    if (mode_r) begin
      outcome_nxt = OUTCOME_QUERY;
      ototal_nxt  = total_r;
    end else if (hit_any_r) begin
      wr_en    = 1'b1;
      wr_stage = hit_stage_r;
      if (!hit_empty_r) begin
        wr_cnt = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
      end
    end else if (replace) begin
      wr_en       = 1'b1;
      wr_stage    = min_stage_r;
      outcome_nxt = OUTCOME_REPLACED;
      okey_nxt    = KEY_W'(min_key_r);
      ocount_nxt  = KEY_W'(min_cnt_r);
    end else begin
      outcome_nxt = OUTCOME_DROPPED;
      okey_nxt    = KEY_W'(key_r);
      ocount_nxt  = KEY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_outcome_r <= outcome_nxt;
      res_key_r     <= okey_nxt;
      res_count_r   <= ocount_nxt;
      res_total_r   <= ototal_nxt;
    end
  end

  assign sts.clear_done = (clr_cnt_r == IDX_W'(SLOTS_PER_STAGE - 1));
  assign sts.out_free   = !res_valid_r || res_ready;

  assign res_valid   = res_valid_r;
  assign res_outcome = res_outcome_r;
  assign res_key     = res_key_r;
  assign res_count   = res_count_r;
  assign res_total   = res_total_r;

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.index |-> (idx_w[0] <= IDX_W'(SLOTS_PER_STAGE - 1)))
    else $error("slot index reduction left a value beyond the stage size");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> res_valid_r)
    else $error("committed result not presented");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !mode_r && !hit_any_r) |-> (min_cnt_r != '0))
    else $error("replacement candidate is an empty slot");

endmodule

`default_nettype wire
